// ===== hw/rtl/sensor_history_window_stats_core_macros.svh =====
// ----------------------------------------------------------------------------
// sensor history window stats - assertion macros
// shared concurrent assertion forms, clocked on clock and quiet in reset
// ----------------------------------------------------------------------------
`ifndef SENSOR_HISTORY_WINDOW_STATS_CORE_MACROS_SVH
`define SENSOR_HISTORY_WINDOW_STATS_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SHWS_ASSERT_HOLDS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SHWS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/shws_pkg.sv =====
// ----------------------------------------------------------------------------
// shws_pkg
// transaction types, field widths and codes of the sensor history window core
// ----------------------------------------------------------------------------
`default_nettype none

package shws_pkg;

   // field widths
   localparam int VALUE_W  = 16;
   localparam int CNT_W    = 7;
   localparam int MC_W     = 3;
   localparam int AGE_W    = 6;
   localparam int MSEL_W   = 2;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int SUM_W    = VALUE_W + CNT_W;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STATS = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd3;

   // request transaction
   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic [MC_W-1:0]           metric_count;
      logic signed [VALUE_W-1:0] metric_value_0;
      logic signed [VALUE_W-1:0] metric_value_1;
      logic signed [VALUE_W-1:0] metric_value_2;
      logic signed [VALUE_W-1:0] metric_value_3;
      logic [AGE_W-1:0]          entry_age;
      logic [MSEL_W-1:0]         metric_select;
   } req_type;

   // response transaction
   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] read_value;
      logic [MC_W-1:0]           read_metric_count;
      logic signed [VALUE_W-1:0] min_value;
      logic signed [VALUE_W-1:0] max_value;
      logic signed [VALUE_W-1:0] avg_value;
      logic [CNT_W-1:0]          fill_count;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/shws_ram.sv =====
// ----------------------------------------------------------------------------
// shws_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module shws_ram #(
   parameter int WIDTH = 67,
   parameter int DEPTH = 64
) (
   input  wire logic                                     clock,
   input  wire logic                                     we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                         wdata,
   input  wire logic                                     re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/shws_div.sv =====
// ----------------------------------------------------------------------------
// shws_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module shws_div #(
   parameter int NUM_W = 22,
   parameter int DEN_W = 7
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic                  done,
   output logic      [NUM_W-1:0] quot
);

   localparam int CW = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   // trial subtraction of the divisor from the shifted remainder
   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      diff  = trial - {1'b0, den_ff};
      ge    = (trial >= {1'b0, den_ff});
   end

   // iteration control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NUM_W);
         rem_in  = '0;
         quo_in  = numer;
         den_in  = denom;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/sensor_history_window_stats_core.sv =====
// ----------------------------------------------------------------------------
// sensor_history_window_stats_core
// ring-buffer history window of sensor readings with read and min/max/mean
// ----------------------------------------------------------------------------
// One request is taken when start is high and busy is low; each request gives
// exactly one response, shown on rsp_item for a single cycle with rsp_strobe
// high, and the receiver cannot stall it. A push, the unused kind and a read
// or stats request that fails on the window state alone answer in the cycle
// after they are taken and leave busy low, so such requests can follow back
// to back. A read that fetches an entry answers from the registered ram read
// data through the S_READ state. A stats request fetches every held reading
// one per cycle through the single read port of the window ram; unless a held
// reading lacks the metric, the sum then goes through a divider that yields
// one quotient bit per cycle. busy is high from the cycle after any other read
// or stats request is taken and is already low in the cycle its response is
// shown. The capacity register is written only while busy and start are low,
// and empties the window.
`default_nettype none

module sensor_history_window_stats_core #(
   parameter int DEPTH   = 64,
   parameter int METRICS = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire shws_pkg::req_type       req_item,
   output logic                         rsp_strobe,
   output shws_pkg::rsp_type            rsp_item,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [shws_pkg::CNT_W-1:0] csr_data
);

   import shws_pkg::*;

   `include "sensor_history_window_stats_core_macros.svh"

   localparam int RAM_AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ENTRY_W = METRICS * VALUE_W + MC_W;
   localparam int MAG_W   = SUM_W - 1;
   localparam logic [CNT_W-1:0] CAP_MAX   = (DEPTH > 127) ? 7'd127 : CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CAP_RESET = (DEPTH < 64) ? CNT_W'(DEPTH) : 7'd64;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_WALK,
      S_DIV
   } state_type;

   state_type                 state_ff, state_in;
   req_type                   req_ff, req_in;
   rsp_type                   rsp_ff, rsp_in;
   logic                      rsp_strobe_ff, rsp_strobe_in;
   logic [CNT_W-1:0]          cap_ff, cap_in;
   logic [CNT_W-1:0]          head_ff, head_in;
   logic [CNT_W-1:0]          oldest_ff, oldest_in;
   logic [CNT_W-1:0]          held_ff, held_in;
   logic [CNT_W-1:0]          walk_slot_ff, walk_slot_in;
   logic [CNT_W-1:0]          issue_cnt_ff, issue_cnt_in;
   logic                      pend_ff, pend_in;
   logic                      first_ff, first_in;
   logic                      miss_ff, miss_in;
   logic signed [VALUE_W-1:0] min_ff, min_in;
   logic signed [VALUE_W-1:0] max_ff, max_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;

   logic                      accept;
   logic                      csr_fire;
   logic [CNT_W-1:0]          cap_wr;
   logic [CNT_W:0]            age_sum;
   logic [CNT_W-1:0]          age_slot;
   logic [MC_W-1:0]           push_count;
   logic [ENTRY_W-1:0]        push_word;
   logic [3:0][VALUE_W-1:0]   in_vals;
   logic                      ram_we;
   logic                      ram_re;
   logic [RAM_AW-1:0]         ram_raddr;
   logic [ENTRY_W-1:0]        ram_rdata;
   logic [MC_W-1:0]           rd_count;
   logic signed [VALUE_W-1:0] sel_val;
   logic                      sel_missing;
   logic                      div_start;
   logic                      div_done;
   logic [MAG_W-1:0]          div_numer;
   logic [MAG_W-1:0]          div_quot;
   logic [MAG_W-1:0]          avg_bits;

   // ring pointer step with wrap at the capacity
   function automatic logic [CNT_W-1:0] wrap_inc(input logic [CNT_W-1:0] x,
                                                 input logic [CNT_W-1:0] lim);
      logic [CNT_W-1:0] nx;
      nx = x + 1'b1;
      return (nx == lim) ? '0 : nx;
   endfunction

   // handshakes; a capacity write waits while a request is offered
   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = !busy && !start;
   assign csr_fire  = csr_valid && csr_ready;

   // capacity write clamped to one .. depth
   always_comb begin
      cap_wr = csr_data;
      if (csr_data == '0) begin
         cap_wr = 7'd1;
      end else if (csr_data > CAP_MAX) begin
         cap_wr = CAP_MAX;
      end
   end

   // slot of the requested age, one compare and subtract
   always_comb begin
      age_sum = {1'b0, oldest_ff} + {2'b00, req_item.entry_age};
      if (age_sum >= {1'b0, cap_ff}) begin
         age_sum = age_sum - {1'b0, cap_ff};
      end
      age_slot = age_sum[CNT_W-1:0];
   end

   // pushed reading: clamped count above the metric values
   always_comb begin
      in_vals    = {req_item.metric_value_3, req_item.metric_value_2,
                    req_item.metric_value_1, req_item.metric_value_0};
      push_count = req_item.metric_count;
      if (32'(req_item.metric_count) > METRICS) begin
         push_count = MC_W'(METRICS);
      end
      push_word = '0;
      push_word[ENTRY_W-1 -: MC_W] = push_count;
      for (int m = 0; m < METRICS; m++) begin
         if (m < 4) begin
            push_word[m*VALUE_W +: VALUE_W] = in_vals[m[1:0]];
         end
      end
   end

   // fields of the entry read back
   always_comb begin
      rd_count = ram_rdata[ENTRY_W-1 -: MC_W];
      sel_val  = '0;
      for (int m = 0; m < METRICS; m++) begin
         if (m == int'(req_ff.metric_select)) begin
            sel_val = ram_rdata[m*VALUE_W +: VALUE_W];
         end
      end
      sel_missing = ({1'b0, req_ff.metric_select} >= rd_count) ||
                    (int'(req_ff.metric_select) >= METRICS);
   end

   // divider operands and signed mean
   assign div_numer = sum_ff[SUM_W-1] ? MAG_W'(-sum_ff) : sum_ff[MAG_W-1:0];
   assign avg_bits  = sum_ff[SUM_W-1] ? (~div_quot + 1'b1) : div_quot;

   // window ram: one entry per slot
   shws_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (RAM_AW'(head_ff)),
      .wdata (push_word),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // mean divider
   shws_div #(
      .NUM_W (MAG_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (held_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      cap_in        = cap_ff;
      head_in       = head_ff;
      oldest_in     = oldest_ff;
      held_in       = held_ff;
      walk_slot_in  = walk_slot_ff;
      issue_cnt_in  = issue_cnt_ff;
      pend_in       = 1'b0;
      first_in      = first_ff;
      miss_in       = miss_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      sum_in        = sum_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_raddr     = '0;
      div_start     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in            = req_item;
               rsp_in            = '0;
               rsp_in.fill_count = held_ff;
               case (req_item.kind)
                  KIND_PUSH: begin
                     ram_we  = 1'b1;
                     head_in = wrap_inc(head_ff, cap_ff);
                     if (held_ff == cap_ff) begin
                        oldest_in = wrap_inc(oldest_ff, cap_ff);
                     end else begin
                        held_in = held_ff + 1'b1;
                     end
                     rsp_in.fill_count = held_in;
                     rsp_strobe_in     = 1'b1;
                  end
                  KIND_READ: begin
                     if (held_ff == '0) begin
                        rsp_in.status = STATUS_EMPTY;
                        rsp_strobe_in = 1'b1;
                     end else if ({1'b0, req_item.entry_age} >= held_ff) begin
                        rsp_in.status = STATUS_RANGE;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = RAM_AW'(age_slot);
                        state_in  = S_READ;
                     end
                  end
                  KIND_STATS: begin
                     if (held_ff == '0) begin
                        rsp_in.status = STATUS_EMPTY;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        walk_slot_in = oldest_ff;
                        issue_cnt_in = '0;
                        first_in     = 1'b1;
                        miss_in      = 1'b0;
                        sum_in       = '0;
                        state_in     = S_WALK;
                     end
                  end
                  default: begin
                     rsp_in.status = STATUS_OK;
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end

         S_READ: begin
            rsp_in                   = '0;
            rsp_in.fill_count        = held_ff;
            rsp_in.read_metric_count = rd_count;
            if (sel_missing) begin
               rsp_in.status = STATUS_MISSING;
            end else begin
               rsp_in.status     = STATUS_OK;
               rsp_in.read_value = sel_val;
            end
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end

         S_WALK: begin
            // fetch the next held reading, oldest first
            if (issue_cnt_ff != held_ff) begin
               ram_re       = 1'b1;
               ram_raddr    = RAM_AW'(walk_slot_ff);
               walk_slot_in = wrap_inc(walk_slot_ff, cap_ff);
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end
            pend_in = ram_re;
            // fold in the reading fetched last cycle
            if (pend_ff) begin
               if (sel_missing) begin
                  miss_in = 1'b1;
               end else begin
                  first_in = 1'b0;
                  if (first_ff || (sel_val < min_ff)) begin
                     min_in = sel_val;
                  end
                  if (first_ff || (sel_val > max_ff)) begin
                     max_in = sel_val;
                  end
                  sum_in = sum_ff + {{(SUM_W-VALUE_W){sel_val[VALUE_W-1]}}, sel_val};
               end
            end
            // all fetched and folded
            if ((issue_cnt_ff == held_ff) && !pend_ff) begin
               if (miss_ff) begin
                  rsp_in            = '0;
                  rsp_in.status     = STATUS_MISSING;
                  rsp_in.fill_count = held_ff;
                  rsp_strobe_in     = 1'b1;
                  state_in          = S_IDLE;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end
         end

         S_DIV: begin
            if (div_done) begin
               rsp_in            = '0;
               rsp_in.status     = STATUS_OK;
               rsp_in.min_value  = min_ff;
               rsp_in.max_value  = max_ff;
               rsp_in.avg_value  = avg_bits[VALUE_W-1:0];
               rsp_in.fill_count = held_ff;
               rsp_strobe_in     = 1'b1;
               state_in          = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // capacity write empties the window
      if (csr_fire) begin
         cap_in    = cap_wr;
         head_in   = '0;
         oldest_in = '0;
         held_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         cap_ff        <= CAP_RESET;
         head_ff       <= '0;
         oldest_ff     <= '0;
         held_ff       <= '0;
         issue_cnt_ff  <= '0;
         pend_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         cap_ff        <= cap_in;
         head_ff       <= head_in;
         oldest_ff     <= oldest_in;
         held_ff       <= held_in;
         issue_cnt_ff  <= issue_cnt_in;
         pend_ff       <= pend_in;
      end
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      walk_slot_ff <= walk_slot_in;
      first_ff     <= first_in;
      miss_ff      <= miss_in;
      min_ff       <= min_in;
      max_ff       <= max_in;
      sum_ff       <= sum_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // checks
   `SHWS_ASSERT_HOLDS(a_held_within_cap, 1'b1, held_ff <= cap_ff,
                      "held count above capacity")
   `SHWS_ASSERT_HOLDS(a_ptrs_within_cap, 1'b1, (head_ff < cap_ff) && (oldest_ff < cap_ff),
                      "ring pointer beyond capacity")
   `SHWS_ASSERT_HOLDS(a_walk_bounded, state_ff == S_WALK, issue_cnt_ff <= held_ff,
                      "walk fetched more than held")
   `SHWS_ASSERT_HOLDS(a_div_done_in_div, div_done, state_ff == S_DIV,
                      "divider finished outside the divide phase")
   `SHWS_ASSERT_NEXT(a_push_answers,
                     accept && (req_item.kind == KIND_PUSH) && !csr_fire,
                     rsp_strobe && (held_ff != '0),
                     "push did not answer with a non-empty window")

endmodule

`default_nettype wire

// ===== test/sensor_history_window_stats_core_tb.sv =====
// ----------------------------------------------------------------------------
// sensor_history_window_stats_core_tb
// self-checking bench for the sensor history window core: a queue-fed driver
// sends push, read, stats and unused-kind requests; an in-bench window model
// predicts each response, and the monitor checks every strobed response
// field by field. It runs over several capacity settings and idle patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_history_window_stats_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import shws_pkg::*;

   localparam int WINDOW_DEPTH   = 64;
   localparam int WINDOW_METRICS = 4;
   localparam int STALL_LIMIT    = 2000;
   localparam int TAIL_CYCLES    = 100;
   localparam int REQ_W          = $bits(req_type);
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   req_type            req_item = '0;
   logic               rsp_strobe;
   rsp_type            rsp_item;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CNT_W-1:0]   csr_data = '0;

   // window model state
   logic signed [VALUE_W-1:0] held_values [WINDOW_DEPTH][WINDOW_METRICS];
   logic [MC_W-1:0]           held_counts [WINDOW_DEPTH];
   int                        window_head;
   int                        window_held;
   int                        window_capacity;

   // stimulus and expectations
   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   rsp_type oldest_rsp;
   int      queued_total   = 0;
   int      accepted_total = 0;
   int      sender_idle_pct = 0;
   bit      took_item = 1'b0;
   int      fault_count = 0;
   int      stall_cycles = 0;
   int      capacity_writes = 0;
   int      kind_seen [4] = '{default: 0};
   int      status_seen [4] = '{default: 0};

   sensor_history_window_stats_core #(
      .DEPTH   (WINDOW_DEPTH),
      .METRICS (WINDOW_METRICS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   function automatic int slot_at_age(int age);
      int oldest;
      oldest = (window_head + window_capacity - window_held) % window_capacity;
      return (oldest + age) % window_capacity;
   endfunction

   // capacity write: clamp into 1..depth and empty the window
   function automatic void configure_window(logic [CNT_W-1:0] value);
      int c;
      c = value;
      if (c == 0) c = 1;
      if (c > WINDOW_DEPTH) c = WINDOW_DEPTH;
      window_capacity = c;
      window_head = 0;
      window_held = 0;
   endfunction

   // applies one request to the window and returns its response
   function automatic rsp_type window_step(req_type r);
      rsp_type o;
      int      slot;
      int      mc;
      longint  sum, lo, hi, v;
      bit      missing;
      o = '0;
      case (r.kind)
         KIND_PUSH: begin
            mc = (r.metric_count > WINDOW_METRICS) ? WINDOW_METRICS : r.metric_count;
            held_values[window_head][0] = r.metric_value_0;
            held_values[window_head][1] = r.metric_value_1;
            held_values[window_head][2] = r.metric_value_2;
            held_values[window_head][3] = r.metric_value_3;
            held_counts[window_head] = MC_W'(mc);
            window_head = (window_head + 1) % window_capacity;
            if (window_held < window_capacity) window_held++;
         end
         KIND_READ: begin
            if (window_held == 0) begin
               o.status = STATUS_EMPTY;
            end else if (r.entry_age >= window_held) begin
               o.status = STATUS_RANGE;
            end else begin
               slot = slot_at_age(r.entry_age);
               o.read_metric_count = held_counts[slot];
               if (r.metric_select >= held_counts[slot])
                  o.status = STATUS_MISSING;
               else
                  o.read_value = held_values[slot][r.metric_select];
            end
         end
         KIND_STATS: begin
            if (window_held == 0) begin
               o.status = STATUS_EMPTY;
            end else begin
               sum = 0;
               lo = 0;
               hi = 0;
               missing = 1'b0;
               for (int i = 0; i < window_held; i++) begin
                  slot = slot_at_age(i);
                  if (r.metric_select >= held_counts[slot]) begin
                     missing = 1'b1;
                     break;
                  end
                  v = held_values[slot][r.metric_select];
                  if (i == 0 || v < lo) lo = v;
                  if (i == 0 || v > hi) hi = v;
                  sum += v;
               end
               if (missing) begin
                  o.status = STATUS_MISSING;
               end else begin
                  o.min_value = VALUE_W'(lo);
                  o.max_value = VALUE_W'(hi);
                  // integer division truncates toward zero
                  o.avg_value = VALUE_W'(sum / window_held);
               end
            end
         end
         default: ;
      endcase
      o.fill_count = CNT_W'(window_held);
      return o;
   endfunction

   // ------------------------------------------------------------ stimulus

   function automatic logic [VALUE_W-1:0] draw_value();
      logic [VALUE_W-1:0] corners [4];
      corners = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
      if ($urandom_range(7) == 0) return corners[$urandom_range(3)];
      return VALUE_W'($urandom);
   endfunction

   function automatic void queue_request(req_type r);
      pending_reqs.push_back(r);
      queued_total++;
   endfunction

   function automatic void push_item(int mc, logic [VALUE_W-1:0] v0, logic [VALUE_W-1:0] v1,
                                     logic [VALUE_W-1:0] v2, logic [VALUE_W-1:0] v3);
      req_type r;
      r.kind = KIND_PUSH;
      r.metric_count = MC_W'(mc);
      r.metric_value_0 = v0;
      r.metric_value_1 = v1;
      r.metric_value_2 = v2;
      r.metric_value_3 = v3;
      r.entry_age = AGE_W'($urandom);
      r.metric_select = MSEL_W'($urandom);
      queue_request(r);
   endfunction

   function automatic void query_item(logic [KIND_W-1:0] kind, int age, int msel);
      req_type r;
      r = req_type'(REQ_W'({$urandom, $urandom, $urandom}));
      r.kind = kind;
      r.entry_age = AGE_W'(age);
      r.metric_select = MSEL_W'(msel);
      queue_request(r);
   endfunction

   // mostly well-formed requests; short readings at short_pct of pushes
   function automatic req_type draw_request(int short_pct);
      req_type r;
      int      pick;
      r = req_type'(REQ_W'({$urandom, $urandom, $urandom}));
      r.metric_value_0 = draw_value();
      r.metric_value_1 = draw_value();
      r.metric_value_2 = draw_value();
      r.metric_value_3 = draw_value();
      pick = $urandom_range(99);
      if (pick < 45) begin
         r.kind = KIND_PUSH;
         if ($urandom_range(99) < short_pct)
            r.metric_count = MC_W'($urandom_range(3));
         else
            r.metric_count = MC_W'($urandom_range(7, 4));
      end else if (pick < 73) begin
         r.kind = KIND_READ;
      end else if (pick < 95) begin
         r.kind = KIND_STATS;
      end else begin
         r.kind = KIND_UNUSED;
      end
      if ($urandom_range(99) < 80)
         r.entry_age = AGE_W'($urandom_range(window_capacity - 1));
      else
         r.entry_age = AGE_W'($urandom_range(WINDOW_DEPTH - 1));
      return r;
   endfunction

   // waits for every queued request to be answered and the core to go idle
   task automatic wait_window_idle();
      do @(negedge clock);
      while (accepted_total != queued_total || expected_rsps.size() != 0 || busy);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_capacity(logic [CNT_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      configure_window(value);
      capacity_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(int idle_pct, int short_pct, int count);
      sender_idle_pct = idle_pct;
      for (int i = 0; i < count; i++)
         queue_request(draw_request(short_pct));
      wait_window_idle();
   endtask

   // ------------------------------------------------------- driver/monitor

   // driver: next queued transaction once the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took_item) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            start    <= 1'b1;
            req_item <= pending_reqs.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   function automatic void check_field(string name, logic [VALUE_W-1:0] want_v,
                                       logic [VALUE_W-1:0] got_v);
      if (got_v !== want_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, $signed(want_v), $signed(got_v));
         fault_count++;
      end
   endfunction

   // monitor: check responses, predict accepted requests
   always @(posedge clock) begin
      took_item = 1'b0;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_rsps.size() == 0) begin
               $error("response with no request outstanding");
               fault_count++;
            end else begin
               oldest_rsp = expected_rsps.pop_front();
               check_field("status", oldest_rsp.status, rsp_item.status);
               check_field("read_value", oldest_rsp.read_value, rsp_item.read_value);
               check_field("read_metric_count", oldest_rsp.read_metric_count,
                           rsp_item.read_metric_count);
               check_field("min_value", oldest_rsp.min_value, rsp_item.min_value);
               check_field("max_value", oldest_rsp.max_value, rsp_item.max_value);
               check_field("avg_value", oldest_rsp.avg_value, rsp_item.avg_value);
               check_field("fill_count", oldest_rsp.fill_count, rsp_item.fill_count);
               status_seen[oldest_rsp.status]++;
            end
         end
         if (start && !busy) begin
            expected_rsps.push_back(window_step(req_item));
            kind_seen[req_item.kind]++;
            accepted_total++;
            took_item = 1'b1;
         end
      end
   end

   // watchdog on cycles with no request taken and no capacity write
   always @(posedge clock) begin
      if (reset || (start && !busy) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("** sensor_history_window_stats_core: FAILED **");
         $finish;
      end
   end

   // ------------------------------------------------------------- sequence

   initial begin
      configure_window(7'd64);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty window, corner values, count clamping, missing metrics
      query_item(KIND_READ, 0, 0);
      query_item(KIND_STATS, 0, 3);
      query_item(KIND_UNUSED, 63, 3);
      push_item(7, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF);
      push_item(4, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001);
      push_item(5, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      push_item(6, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      query_item(KIND_READ, 0, 3);
      query_item(KIND_READ, 3, 0);
      query_item(KIND_READ, 4, 0);
      query_item(KIND_READ, 63, 2);
      query_item(KIND_STATS, 0, 0);
      query_item(KIND_STATS, 0, 1);
      query_item(KIND_STATS, 0, 2);
      query_item(KIND_STATS, 0, 3);
      push_item(1, 16'h1234, 16'hABCD, 16'h5555, 16'hAAAA);
      query_item(KIND_STATS, 0, 1);
      query_item(KIND_READ, 4, 1);
      push_item(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      query_item(KIND_READ, 5, 0);
      query_item(KIND_STATS, 0, 0);
      query_item(KIND_UNUSED, 0, 0);
      push_item(3, 16'hFFFF, 16'h0001, 16'h8001, 16'h7FFE);
      query_item(KIND_READ, 6, 2);
      run_phase(0, 10, 226);

      write_capacity(7'd0);
      run_phase(48, 10, 230);
      write_capacity(7'd127);
      run_phase(6, 0, 230);
      write_capacity(7'd1);
      run_phase(0, 20, 230);
      write_capacity(CNT_W'($urandom_range(16, 2)));
      run_phase(48, 10, 230);
      write_capacity(7'd64);
      run_phase(48, 0, 230);
      write_capacity(CNT_W'($urandom_range(127)));
      run_phase(6, 5, 230);

      // tail: any stray response would be flagged by the monitor
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("ran %0d requests (%0d push, %0d read, %0d stats, %0d unused), %0d cap writes",
               accepted_total, kind_seen[KIND_PUSH], kind_seen[KIND_READ],
               kind_seen[KIND_STATS], kind_seen[KIND_UNUSED], capacity_writes);
      $display("statuses seen: %0d ok, %0d empty, %0d age out of range, %0d metric missing",
               status_seen[STATUS_OK], status_seen[STATUS_EMPTY],
               status_seen[STATUS_RANGE], status_seen[STATUS_MISSING]);
      if (fault_count == 0 && expected_rsps.size() == 0)
         $display("** sensor_history_window_stats_core: PASSED **");
      else
         $display("** sensor_history_window_stats_core: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/shws_pkg.sv
hw/rtl/shws_ram.sv
hw/rtl/shws_div.sv
hw/rtl/sensor_history_window_stats_core.sv
test/sensor_history_window_stats_core_tb.sv
